>>> hw/rtl/f2f8_pkg.sv
package f2f8_pkg;

    // rounding mode codes
    typedef enum logic [2:0] {
        RM_NEAREST_EVEN     = 3'd0,
        RM_TO_ZERO          = 3'd1,
        RM_UP               = 3'd2,
        RM_DOWN             = 3'd3,
        RM_HALF_AWAY        = 3'd4,
        RM_STOCHASTIC       = 3'd5,
        RM_STOCH_RNE_DENORM = 3'd6
    } t_round_mode;

    // configuration register indexes
    typedef enum logic [2:0] {
        CFG_EXP_WIDTH    = 3'd0,
        CFG_MANT_WIDTH   = 3'd1,
        CFG_EXP_BIAS     = 3'd2,
        CFG_ROUND_MODE   = 3'd3,
        CFG_FLUSH_DENORM = 3'd4,
        CFG_CLIP_TO_MAX  = 3'd5
    } t_cfg_index;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 6;

    // register values after reset
    localparam logic [2:0] RST_EXP_WIDTH  = 3'd4;
    localparam logic [2:0] RST_MANT_WIDTH = 3'd3;
    localparam logic [5:0] RST_EXP_BIAS   = 6'd7;

    // exponent width limits
    localparam logic [2:0] EXP_WIDTH_MIN = 3'd2;
    localparam logic [2:0] EXP_WIDTH_MAX = 3'd6;

    // positive nan with exponent and mantissa all ones, for every split of the 7 bits
    localparam logic [7:0] CANONICAL_NAN = 8'h7f;

    // increment decision for a kept magnitude
    function automatic logic round_inc(
        input logic        kept_lsb,
        input logic        half,
        input logic        below,
        input logic        sign,
        input logic [2:0]  mode,
        input logic [31:0] disc,
        input logic [31:0] rnd
    );
        logic inc;
        case (mode)
            RM_TO_ZERO:    inc = 1'b0;
            RM_UP:         inc = !sign && (half || below);
            RM_DOWN:       inc = sign && (half || below);
            RM_HALF_AWAY:  inc = half;
            RM_STOCHASTIC: inc = (disc >= rnd);
            default:       inc = half && (kept_lsb || below);
        endcase
        return inc;
    endfunction

endpackage

>>> hw/rtl/fp32_to_fp8_rounding_convert_core.sv
// Converts a stream of binary32 values to an 8-bit float (sign, exponent, mantissa) whose
// exponent width and bias come from configuration registers; the mantissa takes the
// remaining bits. Each value sits in the input register, then the conversion logic fills
// the result register. A new value can be taken in every cycle; the input stalls only
// while the result register holds an unread result and the input register is also full.
// Stochastic rounding uses the random word that travels with each value. Configuration
// registers are written through their own port, which is always ready, and should only
// change while no value is in flight.
module fp32_to_fp8_rounding_convert_core (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // input channel
    input  logic                            i_valid,
    output logic                            o_stall,
    input  logic [31:0]                     i_value_bits,
    input  logic [31:0]                     i_random_word,
    // result channel
    output logic                            o_valid,
    input  logic                            i_stall,
    output logic [7:0]                      o_result_bits,
    // configuration write channel
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [f2f8_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [f2f8_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import f2f8_pkg::*;

    // configuration registers
    logic [2:0] r_exp_width;
    logic [2:0] r_mant_width;
    logic [5:0] r_exp_bias;
    logic [2:0] r_round_mode;
    logic       r_flush_denorm;
    logic       r_clip_to_max;

    // pipeline registers
    logic        r_in_valid;
    logic [31:0] r_value;
    logic [31:0] r_rnd;
    logic        r_out_valid;
    logic [7:0]  r_result;

    logic out_load;
    logic in_load;

    // conversion signals
    logic [2:0]        ew;
    logic [2:0]        mw;
    logic [7:0]        all_e;
    logic [7:0]        all_m;
    logic [2:0]        mode_d;
    logic [2:0]        mode_n;
    logic              sign;
    logic [7:0]        ef;
    logic [22:0]       frac;
    logic [23:0]       sig;
    logic signed [9:0] ue;
    logic signed [9:0] bias_s;
    logic signed [9:0] min_norm;
    logic signed [9:0] max_e;
    logic signed [9:0] min_e;
    logic signed [9:0] rc_full;
    logic signed [9:0] e;
    logic signed [9:0] e_bias;
    logic              denorm;
    logic [4:0]        rc;
    logic              half;
    logic              below;
    logic [31:0]       disc;
    logic [6:0]        q_trunc;
    logic [6:0]        q_rnd;
    logic              inc;
    logic              carry;
    logic              toward_zero;
    logic              os;
    logic [7:0]        oe;
    logic [7:0]        om;
    logic [7:0]        res_raw;
    logic [7:0]        n_result;

    // configuration writes
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exp_width    <= RST_EXP_WIDTH;
            r_mant_width   <= RST_MANT_WIDTH;
            r_exp_bias     <= RST_EXP_BIAS;
            r_round_mode   <= RM_NEAREST_EVEN;
            r_flush_denorm <= 1'b0;
            r_clip_to_max  <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_EXP_WIDTH:    r_exp_width    <= i_cfg_data[2:0];
                CFG_MANT_WIDTH:   r_mant_width   <= i_cfg_data[2:0];
                CFG_EXP_BIAS:     r_exp_bias     <= i_cfg_data[5:0];
                CFG_ROUND_MODE:   r_round_mode   <= i_cfg_data[2:0];
                CFG_FLUSH_DENORM: r_flush_denorm <= i_cfg_data[0];
                CFG_CLIP_TO_MAX:  r_clip_to_max  <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // handshake: result register loads when empty or being read
    assign out_load = !r_out_valid || !i_stall;
    assign in_load  = !r_in_valid || out_load;
    assign o_stall  = !in_load;
    assign o_valid  = r_out_valid;
    assign o_result_bits = r_result;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_load) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_load && i_valid) begin
            r_value <= i_value_bits;
            r_rnd   <= i_random_word;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load && r_in_valid) begin
            r_result <= n_result;
        end
    end

    // format limits from the registers; mantissa width always follows the exponent width
    always_comb begin
        if (r_exp_width < EXP_WIDTH_MIN) begin
            ew = EXP_WIDTH_MIN;
        end else if (r_exp_width > EXP_WIDTH_MAX) begin
            ew = EXP_WIDTH_MAX;
        end else begin
            ew = r_exp_width;
        end
        mw       = 3'd7 - ew;
        all_e    = 8'((9'd1 << ew) - 9'd1);
        all_m    = 8'((9'd1 << mw) - 9'd1);
        bias_s   = $signed({4'b0000, r_exp_bias});
        min_norm = 10'sd1 - bias_s;
        max_e    = $signed({2'b00, all_e}) - 10'sd1 - bias_s;
        min_e    = min_norm - $signed({7'b0000000, mw}) - 10'sd1;
        mode_d   = (r_round_mode == RM_STOCH_RNE_DENORM) ? RM_NEAREST_EVEN : r_round_mode;
        mode_n   = (r_round_mode == RM_STOCH_RNE_DENORM) ? RM_STOCHASTIC : r_round_mode;
    end

    // field split and rounding position
    always_comb begin
        sign    = r_value[31];
        ef      = r_value[30:23];
        frac    = r_value[22:0];
        sig     = {1'b1, frac};
        ue      = $signed({2'b00, ef}) - 10'sd127;
        denorm  = (ue < min_norm);
        rc_full = 10'sd22 - $signed({7'b0000000, mw}) + (denorm ? (min_norm - ue) : 10'sd0);
        rc      = rc_full[4:0];
        half    = sig[rc];
        below   = |(sig & 24'((25'd1 << rc) - 25'd1));
        disc    = {8'b0, sig} << (5'd31 - rc);
        q_trunc = 7'(sig >> (rc + 5'd1));
        inc     = round_inc(q_trunc[0], half, below, sign, denorm ? mode_d : mode_n,
                            disc, r_rnd);
        if (denorm && r_flush_denorm) begin
            q_rnd = 7'd0;
        end else begin
            q_rnd = q_trunc + {6'b0, inc};
        end
        carry  = (denorm && q_rnd[mw]) || q_rnd[3'(mw + 3'd1)];
        e      = ue + (carry ? 10'sd1 : 10'sd0);
        e_bias = e + bias_s;
        toward_zero = (r_round_mode == RM_TO_ZERO) || (sign && r_round_mode == RM_UP)
                      || (!sign && r_round_mode == RM_DOWN);
    end

    // special values, overflow, underflow and the normal path
    always_comb begin
        os = sign;
        oe = 8'd0;
        om = 8'd0;
        if (ef == 8'hff && frac != 23'd0) begin
            os = 1'b0;
            oe = all_e;
            om = all_m;
        end else if (r_value[30:0] == 31'd0) begin
            oe = 8'd0;
            om = 8'd0;
        end else if (ef == 8'hff) begin
            oe = all_e;
        end else if (ue > max_e) begin
            if (toward_zero) begin
                oe = all_e - 8'd1;
                om = all_m;
            end else begin
                oe = all_e;
            end
        end else if (ue < min_e) begin
            // below half the smallest denormal: only directed rounding gives a nonzero
            if (!r_flush_denorm && mode_d != RM_STOCHASTIC) begin
                om = {7'b0, round_inc(1'b0, 1'b0, 1'b1, sign, mode_d, 32'd0, r_rnd)};
            end
        end else if (e > max_e) begin
            oe = all_e;
        end else if (e < min_norm) begin
            om = r_flush_denorm ? 8'd0 : ({1'b0, q_rnd} & all_m);
        end else begin
            oe = e_bias[7:0];
            om = {1'b0, q_rnd} & all_m;
        end
    end

    // packing and optional clip of infinity to max normal
    always_comb begin
        res_raw = om | (oe << mw) | {os, 7'b0};
        if (r_clip_to_max && ((res_raw >> mw) & all_e) == all_e
            && (res_raw & all_m) == 8'd0) begin
            n_result = res_raw - 8'd1;
        end else begin
            n_result = res_raw;
        end
    end

`ifndef NO_ASSERTIONS
    // an item in the input register moves on when the input side is not stalled
    a_advance : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !o_stall) |=> o_valid)
        else $error("input register item not moved to result register");

    // input stalls only behind a full, stalled result register
    a_stall_cause : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (o_valid && i_stall && r_in_valid))
        else $error("input stalled without a blocked result");

    // any nan gives the canonical nan
    a_nan : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !o_stall && r_value[30:23] == 8'hff && r_value[22:0] != 23'd0)
        |=> (o_result_bits == CANONICAL_NAN))
        else $error("nan input not converted to canonical nan");

    // reset empties the result register
    a_reset : assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("result valid after reset");
`endif

endmodule

>>> tb/tb_fp32_to_fp8_rounding_convert_core.sv
`timescale 1ns / 1ps

module tb_fp32_to_fp8_rounding_convert_core;
    import f2f8_pkg::*;

    // unused rounding code, behaves as nearest even
    localparam logic [2:0] RM_SPARE_CODE  = 3'd7;
    localparam int         FORMAT_PHASES  = 14;
    localparam int         SETTLE_CYCLES  = 6;
    localparam int         PRINT_LIMIT    = 50;

    typedef struct packed {
        logic [31:0] value_bits;
        logic [31:0] random_word;
    } t_fp32_item;

    typedef struct packed {
        logic [31:0] value_bits;
        logic [31:0] random_word;
        logic [7:0]  result_bits;
    } t_fp8_expect;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        i_valid       = 1'b0;
    logic        o_stall;
    logic [31:0] i_value_bits  = '0;
    logic [31:0] i_random_word = '0;
    logic        o_valid;
    logic        i_stall       = 1'b0;
    logic [7:0]  o_result_bits;
    logic        i_cfg_valid   = 1'b0;
    logic        o_cfg_ready;
    logic [CFG_INDEX_W-1:0] i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_data  = '0;

    // shadow copy of the format registers
    logic [2:0] fmt_exp_width   = RST_EXP_WIDTH;
    logic [2:0] fmt_mant_width  = RST_MANT_WIDTH;
    logic [5:0] fmt_exp_bias    = RST_EXP_BIAS;
    logic [2:0] fmt_round_mode  = RM_NEAREST_EVEN;
    logic       fmt_flush_denorm = 1'b0;
    logic       fmt_clip_to_max  = 1'b0;

    t_fp32_item  fp32_pending[$];
    t_fp8_expect fp8_expected[$];
    t_fp8_expect oldest_fp8;
    logic        input_held = 1'b0;
    bit          no_idle    = 1'b0;
    int          error_count     = 0;
    int          values_sent     = 0;
    int          results_checked = 0;

    fp32_to_fp8_rounding_convert_core u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_value_bits  (i_value_bits),
        .i_random_word (i_random_word),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_result_bits (o_result_bits),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always #10 i_clk = ~i_clk;

    task automatic report_mismatch(string what);
        error_count++;
        if (error_count <= PRINT_LIMIT) begin
            $display("[%0t] MISMATCH %s", $time, what);
        end
    endtask

    // exponent width as the block uses it, clamped to the legal span
    function automatic int active_exp_width();
        int ew;
        ew = int'(fmt_exp_width);
        if (ew < int'(EXP_WIDTH_MIN)) ew = int'(EXP_WIDTH_MIN);
        if (ew > int'(EXP_WIDTH_MAX)) ew = int'(EXP_WIDTH_MAX);
        return ew;
    endfunction

    // whether the kept magnitude steps up by one unit
    function automatic logic rounds_up(logic kept_odd, logic half, logic below, logic sgn,
                                       logic [2:0] mode, logic [31:0] disc,
                                       logic [31:0] rnd);
        logic step;
        case (mode)
            RM_TO_ZERO:    step = 1'b0;
            RM_UP:         step = !sgn && (half || below);
            RM_DOWN:       step = sgn && (half || below);
            RM_HALF_AWAY:  step = half;
            RM_STOCHASTIC: step = (disc >= rnd);
            default:       step = half && (kept_odd || below);
        endcase
        return step;
    endfunction

    // expected 8-bit float for one binary32 value under the current format
    function automatic logic [7:0] convert_fp8(logic [31:0] x, logic [31:0] rnd);
        int          ew, mw, bias, min_norm, max_e, min_e, ue, e, rc;
        logic [7:0]  all_e, all_m, oe, om, res, ef;
        logic [2:0]  mode_sub, mode_norm;
        logic        sgn, os, denorm, half, below;
        logic [22:0] frac;
        logic [31:0] sig, disc, q;
        ew       = active_exp_width();
        mw       = 7 - ew;
        bias     = int'(fmt_exp_bias);
        min_norm = 1 - bias;
        max_e    = (1 << ew) - 2 - bias;
        min_e    = min_norm - mw - 1;
        all_e    = 8'((1 << ew) - 1);
        all_m    = 8'((1 << mw) - 1);
        mode_sub  = fmt_round_mode;
        mode_norm = fmt_round_mode;
        if (fmt_round_mode == RM_STOCH_RNE_DENORM) begin
            mode_sub  = RM_NEAREST_EVEN;
            mode_norm = RM_STOCHASTIC;
        end
        sgn  = x[31];
        ef   = x[30:23];
        frac = x[22:0];
        os   = sgn;
        oe   = '0;
        om   = '0;
        if (ef == 8'hff && frac != '0) begin
            // any nan collapses to the canonical positive one
            os = 1'b0;
            oe = all_e;
            om = all_m;
        end else if (x[30:0] == '0) begin
            oe = '0;
            om = '0;
        end else if (ef == 8'hff) begin
            oe = all_e;
            om = '0;
        end else begin
            ue  = int'(ef) - 127;
            sig = {8'd0, 1'b1, frac};
            if (ue > max_e) begin
                // overflow: max normal when rounding heads towards zero
                if (fmt_round_mode == RM_TO_ZERO || (sgn && fmt_round_mode == RM_UP) ||
                    (!sgn && fmt_round_mode == RM_DOWN)) begin
                    oe = all_e - 8'd1;
                    om = all_m;
                end else begin
                    oe = all_e;
                    om = '0;
                end
            end else if (ue < min_e) begin
                // below half the smallest denormal
                if (!fmt_flush_denorm && mode_sub != RM_STOCHASTIC &&
                    rounds_up(1'b0, 1'b0, 1'b1, sgn, mode_sub, '0, rnd)) begin
                    om = 8'd1;
                end
            end else begin
                denorm = (ue < min_norm);
                rc     = 22 - mw + (denorm ? (min_norm - ue) : 0);
                half   = sig[rc];
                below  = (sig & ((32'd1 << rc) - 32'd1)) != '0;
                disc   = sig << (31 - rc);
                q      = sig >> (rc + 1);
                e      = ue;
                if (denorm) begin
                    if (fmt_flush_denorm) q = '0;
                    else if (rounds_up(q[0], half, below, sgn, mode_sub, disc, rnd)) q = q + 1;
                end else if (rounds_up(q[0], half, below, sgn, mode_norm, disc, rnd)) begin
                    q = q + 1;
                end
                // carry into the next binade
                if ((denorm && q[mw]) || q[mw + 1]) e++;
                if (e > max_e) begin
                    oe = all_e;
                    om = '0;
                end else begin
                    if (e < min_norm) begin
                        oe = '0;
                        if (fmt_flush_denorm) q = '0;
                    end else begin
                        oe = 8'(e + bias);
                    end
                    om = q[7:0] & all_m;
                end
            end
        end
        res = om | (oe << mw) | {os, 7'd0};
        if (fmt_clip_to_max && ((res >> mw) & all_e) == all_e && (res & all_m) == '0) begin
            res = res - 8'd1;
        end
        return res;
    endfunction

    // random value, mostly with exponents around the current format's range
    function automatic t_fp32_item random_fp32();
        int          ew, mw, bias, lo, hi, ue, kind;
        logic [31:0] v, r;
        logic [22:0] frac;
        ew   = active_exp_width();
        mw   = 7 - ew;
        bias = int'(fmt_exp_bias);
        lo   = (1 - bias) - mw - 4;
        hi   = (1 << ew) - bias;
        kind = $urandom_range(99);
        if (kind < 10) begin
            frac = 23'($urandom);
            case ($urandom_range(3))
                0: v = 32'h0000_0000;
                1: v = 32'h7f80_0000;
                2: v = {9'h0ff, (frac == '0) ? 23'd1 : frac};
                default: v = {9'h000, frac};
            endcase
            v[31] = 1'($urandom_range(1));
        end else if (kind < 88) begin
            ue = lo + int'($urandom_range(hi - lo));
            if (ue < -126) ue = -126;
            if (ue > 127) ue = 127;
            v = $urandom;
            v[30:23] = 8'(ue + 127);
            // clear low bits now and then to land on ties and exact values
            if ($urandom_range(2) == 0) v = v & ~((32'd1 << $urandom_range(22)) - 32'd1);
        end else begin
            v = $urandom;
        end
        case ($urandom_range(9))
            0:       r = '0;
            1:       r = '1;
            default: r = $urandom;
        endcase
        return '{v, r};
    endfunction

    // one register write on the configuration channel
    task automatic cfg_write(t_cfg_index idx, logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_EXP_WIDTH:    fmt_exp_width    = data[2:0];
            CFG_MANT_WIDTH:   fmt_mant_width   = data[2:0];
            CFG_EXP_BIAS:     fmt_exp_bias     = data[5:0];
            CFG_ROUND_MODE:   fmt_round_mode   = data[2:0];
            CFG_FLUSH_DENORM: fmt_flush_denorm = data[0];
            CFG_CLIP_TO_MAX:  fmt_clip_to_max  = data[0];
            default: ;
        endcase
    endtask

    task automatic set_format(logic [2:0] ew, logic [2:0] mw, logic [5:0] bias,
                              logic [2:0] rm, logic flush, logic clip);
        cfg_write(CFG_EXP_WIDTH, {3'd0, ew});
        cfg_write(CFG_MANT_WIDTH, {3'd0, mw});
        cfg_write(CFG_EXP_BIAS, bias);
        cfg_write(CFG_ROUND_MODE, {3'd0, rm});
        cfg_write(CFG_FLUSH_DENORM, {5'd0, flush});
        cfg_write(CFG_CLIP_TO_MAX, {5'd0, clip});
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // wait until every conversion in flight has come back
    task automatic wait_drained();
        while (fp32_pending.size() != 0 || fp8_expected.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // edge cases under the reset format (4-bit exponent, bias 7)
    task automatic queue_directed();
        logic [31:0] edge_vals[20];
        edge_vals = '{
            32'h0000_0000, 32'h8000_0000, 32'h7f80_0000, 32'hff80_0000,
            32'h7fc0_0000, 32'hff80_0001, 32'h0000_0001, 32'h807f_ffff,
            32'h7f7f_ffff, 32'hff7f_ffff, 32'h3f80_0000, 32'hbf80_0000,
            32'h3f88_0000, 32'h3f98_0000, 32'h43f8_0000, 32'h43f0_0000,
            32'h3b00_0000, 32'h3a80_0000, 32'hba80_0001, 32'h3c7f_ffff
        };
        foreach (edge_vals[k]) begin
            fp32_pending.push_back('{edge_vals[k], (k % 2 == 0) ? 32'h0 : 32'hffff_ffff});
        end
    endtask

    // input driver: a stalled transfer is held, otherwise idle or present the next value
    always @(negedge i_clk) begin
        if (!(i_valid && input_held)) begin
            if (fp32_pending.size() != 0 && (no_idle || $urandom_range(99) >= 29)) begin
                i_valid       <= 1'b1;
                i_value_bits  <= fp32_pending[0].value_bits;
                i_random_word <= fp32_pending[0].random_word;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // input transfer: record the expected result
    always @(posedge i_clk) begin
        input_held = i_valid && o_stall;
        if (i_rst_n && i_valid && !o_stall) begin
            fp8_expected.push_back('{i_value_bits, i_random_word,
                                     convert_fp8(i_value_bits, i_random_word)});
            fp32_pending.delete(0);
            values_sent++;
        end
    end

    // result side back-pressure
    always @(negedge i_clk) begin
        i_stall <= !no_idle && ($urandom_range(99) < 29);
    end

    // result monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (fp8_expected.size() == 0) begin
                report_mismatch($sformatf("result %02h with no value outstanding",
                                          o_result_bits));
            end else begin
                oldest_fp8 = fp8_expected.pop_front();
                results_checked++;
                if (o_result_bits !== oldest_fp8.result_bits) begin
                    report_mismatch($sformatf("value %08h rnd %08h: result %02h, want %02h",
                                              oldest_fp8.value_bits, oldest_fp8.random_word,
                                              o_result_bits, oldest_fp8.result_bits));
                end
            end
        end
    end

    initial begin : stimulus
        logic [2:0] ew_tab[13];
        logic [2:0] mw_tab[13];
        logic [5:0] bias_tab[13];
        logic [2:0] rm_tab[13];
        ew_tab   = '{3'd2, 3'd6, 3'd3, 3'd5, 3'd4, 3'd7, 3'd2, 3'd6, 3'd1, 3'd5, 3'd0, 3'd3,
                     3'd4};
        mw_tab   = '{3'd5, 3'd1, 3'd4, 3'd2, 3'd3, 3'd3, 3'd5, 3'd1, 3'd6, 3'd2, 3'd7, 3'd4,
                     3'd0};
        bias_tab = '{6'd0, 6'd63, 6'd3, 6'd15, 6'd7, 6'd31, 6'd1, 6'd62, 6'd7, 6'd20, 6'd5,
                     6'd0, 6'd7};
        rm_tab   = '{RM_NEAREST_EVEN, RM_TO_ZERO, RM_UP, RM_DOWN, RM_HALF_AWAY, RM_STOCHASTIC,
                     RM_STOCH_RNE_DENORM, RM_SPARE_CODE, RM_STOCHASTIC, RM_STOCH_RNE_DENORM,
                     RM_UP, RM_DOWN, RM_HALF_AWAY};

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // phase 0 runs on the reset format, the rest rewrite every register
        for (int p = 0; p < FORMAT_PHASES; p++) begin
            if (p != 0) begin
                wait_drained();
                set_format(ew_tab[p-1], mw_tab[p-1], bias_tab[p-1], rm_tab[p-1],
                           1'(p & 1), 1'((p >> 1) & 1));
            end
            no_idle = (p == 4 || p == 9);
            if (p == 0) queue_directed();
            repeat ((p == 0) ? 30 : 46) fp32_pending.push_back(random_fp32());
        end
        wait_drained();

        $display("converted %0d values over %0d register settings, %0d results checked",
                 values_sent, FORMAT_PHASES, results_checked);
        $display("widths 0..7, biases 0..63, all rounding codes, flush and clip both ways");
        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    // watchdog
    initial begin
        #4_000_000;
        $display("timeout with %0d values queued and %0d results outstanding",
                 fp32_pending.size(), fp8_expected.size());
        $display("DONE: errors detected");
        $finish;
    end

endmodule

>>> fp32_to_fp8_rounding_convert_core.f
hw/rtl/f2f8_pkg.sv
hw/rtl/fp32_to_fp8_rounding_convert_core.sv
tb/tb_fp32_to_fp8_rounding_convert_core.sv
